/* src/kms_pkg.sv */
// Package for the k-way merge selection core.
// Field widths, configuration register indexes and the head record type.
// Standalone; used by kway_merge_select_core.
package kms_pkg;

  localparam int KEY_W  = 48;
  localparam int TAG_W  = 32;
  localparam int WAY_W  = 4;
  localparam int AWAY_W = 5;

  localparam logic CFG_DESCENDING  = 1'b0;
  localparam logic CFG_ACTIVE_WAYS = 1'b1;

  typedef logic signed [KEY_W-1:0] key_t;
  typedef logic [TAG_W-1:0] tag_t;

  typedef struct packed {
    key_t key;
    tag_t tag;
  } head_t;

  localparam int HEAD_W = $bits(head_t);

endpackage

/* src/kms_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// Width and depth set by parameters; no dependencies.
module kms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/kway_merge_select_core.sv */
// Top level of the k-way merge selection core: head store, full flags,
// load/merge control and the scan over all ways. Uses kms_pkg and kms_ram.
// An item taken while merging, or the last load item, starts the scan and
// the emit state registers the result; no item is taken outside idle. The
// scan reads the head RAM one way per cycle; a result held by out_tready
// stalls the next result in the emit state. Other load items need no scan.
// Reset (synchronous, rst_n low): full flags, counters and phase cleared,
// descending = 0, active_ways = 16; head RAM is not cleared.
module kway_merge_select_core #(
  parameter int MAX_WAYS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [79:0]                in_tdata,   // in_key[47:0], in_tag[79:48]
  input  logic                       in_tuser,   // exhausted
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [87:0]                out_tdata,  // win_way[3:0], win_key[51:4],
                                                 // win_tag[83:52], zero pad
  output logic                       out_tuser,  // finished
  input  logic                       cfg_we,
  input  logic                       cfg_addr,
  input  logic [kms_pkg::AWAY_W-1:0] cfg_wdata
);

  import kms_pkg::*;

  localparam int W  = $clog2(MAX_WAYS);
  localparam int CW = W + 1;
  localparam int XW = (CW > AWAY_W) ? CW : AWAY_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]          state_r, state_nxt;
  logic                desc_r;
  logic [AWAY_W-1:0]   aways_r;
  logic [MAX_WAYS-1:0] full_r, full_nxt;
  logic [CW-1:0]       loaded_r, loaded_nxt;
  logic [W-1:0]        refill_r, refill_nxt;
  logic                merging_r, merging_nxt;
  logic [CW-1:0]       rd_idx_r, rd_idx_nxt;
  logic                pend_vld_r, pend_vld_nxt;
  logic [W-1:0]        pend_idx_r;
  logic                found_r, found_nxt;
  logic [W-1:0]        best_idx_r, best_idx_nxt;
  head_t               best_r, best_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_fin_r;
  logic [WAY_W-1:0]    out_way_r;
  head_t               out_head_r;

  logic          in_acc;
  logic          ram_we;
  logic [W-1:0]  ram_waddr;
  head_t         ram_wdata;
  head_t         ram_rdata;
  logic [W-1:0]  put_way;
  logic [XW-1:0] aw_x;
  logic [CW-1:0] act_cnt;
  logic          better;
  logic          emit_go;

  kms_ram #(
    .WIDTH(HEAD_W),
    .DEPTH(MAX_WAYS)
  ) u_head_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(rd_idx_r[W-1:0]),
    .rdata(ram_rdata)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_fin_r;
  assign out_tdata  = {4'd0, out_head_r.tag, out_head_r.key, out_way_r};

  assign aw_x = XW'(aways_r);
  always_comb begin
    if (aways_r == '0) begin
      act_cnt = CW'(1);
    end else if (aw_x > XW'(MAX_WAYS)) begin
      act_cnt = CW'(MAX_WAYS);
    end else begin
      act_cnt = CW'(aw_x);
    end
  end

  assign put_way       = merging_r ? refill_r : loaded_r[W-1:0];
  assign ram_we        = in_acc && !in_tuser;
  assign ram_waddr     = put_way;
  assign ram_wdata.key = in_tdata[KEY_W-1:0];
  assign ram_wdata.tag = in_tdata[KEY_W+TAG_W-1:KEY_W];

  assign better  = !found_r || (desc_r ? (ram_rdata.key > best_r.key)
                                       : (ram_rdata.key < best_r.key));
  assign emit_go = !out_valid_r || out_tready;

  always_comb begin
    state_nxt     = state_r;
    full_nxt      = full_r;
    loaded_nxt    = loaded_r;
    refill_nxt    = refill_r;
    merging_nxt   = merging_r;
    rd_idx_nxt    = rd_idx_r;
    pend_vld_nxt  = 1'b0;
    found_nxt     = found_r;
    best_idx_nxt  = best_idx_r;
    best_nxt      = best_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (!merging_r && (loaded_r == '0)) begin
            full_nxt = '0;
          end
          full_nxt[put_way] = !in_tuser;
          rd_idx_nxt = '0;
          found_nxt  = 1'b0;
          if (merging_r) begin
            state_nxt = ST_SCAN;
          end else begin
            loaded_nxt = loaded_r + CW'(1);
            if (loaded_nxt >= act_cnt) begin
              merging_nxt = 1'b1;
              state_nxt   = ST_SCAN;
            end
          end
        end
      end
      ST_SCAN: begin
        if (pend_vld_r && better) begin
          found_nxt    = 1'b1;
          best_idx_nxt = pend_idx_r;
          best_nxt     = ram_rdata;
        end
        if (rd_idx_r == CW'(MAX_WAYS)) begin
          state_nxt = ST_EMIT;
        end else begin
          pend_vld_nxt = full_r[rd_idx_r[W-1:0]];
          rd_idx_nxt   = rd_idx_r + CW'(1);
        end
      end
      ST_EMIT: begin
        if (emit_go) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
          if (found_r) begin
            refill_nxt = best_idx_r;
          end else begin
            refill_nxt  = '0;
            loaded_nxt  = '0;
            merging_nxt = 1'b0;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      desc_r      <= 1'b0;
      aways_r     <= AWAY_W'(16);
      full_r      <= '0;
      loaded_r    <= '0;
      refill_r    <= '0;
      merging_r   <= 1'b0;
      rd_idx_r    <= '0;
      pend_vld_r  <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      full_r      <= full_nxt;
      loaded_r    <= loaded_nxt;
      refill_r    <= refill_nxt;
      merging_r   <= merging_nxt;
      rd_idx_r    <= rd_idx_nxt;
      pend_vld_r  <= pend_vld_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_DESCENDING:  desc_r  <= cfg_wdata[0];
          CFG_ACTIVE_WAYS: aways_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_idx_r <= rd_idx_r[W-1:0];
    best_idx_r <= best_idx_nxt;
    best_r     <= best_nxt;
    if ((state_r == ST_EMIT) && emit_go) begin
      out_fin_r <= !found_r;
      if (found_r) begin
        out_way_r  <= WAY_W'(best_idx_r);
        out_head_r <= best_r;
      end else begin
        out_way_r  <= '0;
        out_head_r <= '0;
      end
    end
  end

endmodule
